@@ hw/rtl/ddo_pkg.sv @@
// Shared widths, constants, register indexes and the sin/cos step table for the odometry core.
package ddo_pkg;

    localparam int COUNT_WIDTH    = 32;
    localparam int POSITION_WIDTH = 56;
    localparam int TRIG_FRAC_BITS = 24;

    localparam int IN_FIELD_W = 32;
    localparam int OUT_POS_W  = 56;
    localparam int ANGLE_W    = 32;
    localparam int S_TDATA_W  = 2 * IN_FIELD_W;
    localparam int M_TDATA_W  = 2 * OUT_POS_W + ANGLE_W;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_DATA_W-1:0] HALF_DIST_RESET = 24'd256979;
    localparam logic [CFG_DATA_W-1:0] TURN_RESET      = 24'd134185;
    localparam logic                  LEFT_NEG_RESET  = 1'b0;
    localparam logic                  RIGHT_NEG_RESET = 1'b1;

    // Q30 trig arithmetic.
    localparam int Q_FRAC = 30;
    localparam int Q_W    = 31;
    localparam logic [Q_W-1:0] Q_ONE          = 31'h4000_0000;
    localparam logic [Q_W-1:0] QUARTER_PI_Q30 = 31'd843314857;

    localparam int DIV_W      = 7;
    localparam int STEP_IDX_W = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HALF_DIST = 2'd0,
        REG_TURN      = 2'd1,
        REG_LEFT_NEG  = 2'd2,
        REG_RIGHT_NEG = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        STEP_SQ,
        STEP_MUL_W,
        STEP_MUL_S,
        STEP_DIV_X2_U,
        STEP_DIV_W_U,
        STEP_DIV_W_C,
        STEP_END
    } step_kind_t;

    typedef struct packed {
        step_kind_t        kind;
        logic [DIV_W-1:0]  divisor;
    } step_t;

    // Horner evaluation of the sine series (to x^9) and the cosine series (to x^10).
    function automatic step_t trig_step(input logic [STEP_IDX_W-1:0] idx);
        step_t st;
        st.kind    = STEP_END;
        st.divisor = '0;
        unique case (idx)
            5'd0:  st = '{STEP_SQ,       7'd0};
            5'd1:  st = '{STEP_DIV_X2_U, 7'd72};
            5'd2:  st = '{STEP_MUL_W,    7'd0};
            5'd3:  st = '{STEP_DIV_W_U,  7'd42};
            5'd4:  st = '{STEP_MUL_W,    7'd0};
            5'd5:  st = '{STEP_DIV_W_U,  7'd20};
            5'd6:  st = '{STEP_MUL_W,    7'd0};
            5'd7:  st = '{STEP_DIV_W_U,  7'd6};
            5'd8:  st = '{STEP_MUL_S,    7'd0};
            5'd9:  st = '{STEP_DIV_X2_U, 7'd90};
            5'd10: st = '{STEP_MUL_W,    7'd0};
            5'd11: st = '{STEP_DIV_W_U,  7'd56};
            5'd12: st = '{STEP_MUL_W,    7'd0};
            5'd13: st = '{STEP_DIV_W_U,  7'd30};
            5'd14: st = '{STEP_MUL_W,    7'd0};
            5'd15: st = '{STEP_DIV_W_U,  7'd12};
            5'd16: st = '{STEP_MUL_W,    7'd0};
            5'd17: st = '{STEP_DIV_W_C,  7'd2};
            default: st = '{STEP_END,    7'd0};
        endcase
        return st;
    endfunction

endpackage

@@ hw/rtl/ddo_serial_mul.sv @@
// Serial-parallel unsigned multiplier that consumes one multiplier bit per cycle.
module ddo_serial_mul #(
    parameter int A_W = 56,
    parameter int B_W = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]   a_reg;
    logic [A_W-1:0]   hi_reg;
    logic [B_W-1:0]   lo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [A_W:0]     sum;

    assign sum     = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                hi_reg   <= '0;
                lo_reg   <= b;
                cnt_reg  <= CNT_W'(B_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= sum[A_W:1];
                lo_reg  <= {sum[0], lo_reg[B_W-1:1]};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

@@ hw/rtl/ddo_const_div.sv @@
// Restoring divider by a small divisor, one quotient bit per cycle, most significant first.
module ddo_const_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [ddo_pkg::Q_W-1:0]   dividend,
    input  logic [ddo_pkg::DIV_W-1:0] divisor,
    output logic                    done,
    output logic [ddo_pkg::Q_W-1:0]   quotient
);
    localparam int QW    = ddo_pkg::Q_W;
    localparam int DW    = ddo_pkg::DIV_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [QW-1:0]    dvd_reg;
    logic [DW-1:0]    dsr_reg;
    logic [DW-1:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      trial;
    logic [DW:0]      diff;
    logic             ge;

    assign trial    = {rem_reg, dvd_reg[QW-1]};
    assign ge       = trial >= {1'b0, dsr_reg};
    assign diff     = trial - {1'b0, dsr_reg};
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(QW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
                dvd_reg <= {dvd_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

@@ hw/rtl/differential_drive_odometry_core.sv @@
// Top level of the differential-drive odometry core: sequencer, pose state and ports.
//
//  channel  | direction | payload (lowest bits first)
//  s_       | in        | left_count[31:0], right_count[31:0]
//  m_       | out       | x_pos[55:0], y_pos[55:0], heading[31:0]
//  cfg_     | in        | write of register cfg_addr with cfg_wdata
//
// Each item runs fourteen multiplications on the one-bit-per-cycle multiplier and nine
// divisions on the one-bit-per-cycle divider, one after another under the sequencer, which
// also ends the series, rounds sin and cos, and loads the output register.
// The next item is accepted once the result is in the output register, while it waits.
// Synchronous active-low reset clears the pose and last counts and presets the cfg registers.
// A stalled result holds m_tdata; the sequencer waits in its final step until it can load.
module differential_drive_odometry_core #(
    parameter int COUNT_WIDTH    = ddo_pkg::COUNT_WIDTH,
    parameter int POSITION_WIDTH = ddo_pkg::POSITION_WIDTH,
    parameter int TRIG_FRAC_BITS = ddo_pkg::TRIG_FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ddo_pkg::S_TDATA_W-1:0]    s_tdata,   // left_count, right_count
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ddo_pkg::M_TDATA_W-1:0]    m_tdata,   // x_pos, y_pos, heading
    input  logic                             cfg_wr_en,
    input  logic [ddo_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ddo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    localparam int CW     = COUNT_WIDTH;
    localparam int PW     = POSITION_WIDTH;
    localparam int FB     = TRIG_FRAC_BITS;
    localparam int QW     = ddo_pkg::Q_W;
    localparam int QF     = ddo_pkg::Q_FRAC;
    localparam int AW     = ddo_pkg::ANGLE_W;
    localparam int OPW    = ddo_pkg::OUT_POS_W;
    localparam int MA     = CW + ddo_pkg::CFG_DATA_W;
    localparam int MB     = QW;
    localparam int PRW    = MA + MB;
    localparam int SHIFT  = QF - FB;
    localparam int RND_HALF = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
    localparam logic [PRW-1:0] T_HALF  = PRW'(1) << (QF - 2);
    localparam logic [PRW-1:0] DX_HALF = PRW'(1) << (FB - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRAVEL,
        S_TMUL,
        S_TRIG,
        S_ROUND,
        S_DX,
        S_DY,
        S_TURN,
        S_OUT
    } state_t;

    state_t state_reg;
    logic   pending_reg;
    logic [ddo_pkg::STEP_IDX_W-1:0] step_reg;

    logic [ddo_pkg::CFG_DATA_W-1:0] half_dist_reg;
    logic [ddo_pkg::CFG_DATA_W-1:0] turn_reg;
    logic                           left_neg_reg;
    logic                           right_neg_reg;

    logic [CW-1:0] last_left_reg;
    logic [CW-1:0] last_right_reg;
    logic [PW-1:0] pos_x_reg;
    logic [PW-1:0] pos_y_reg;
    logic [AW-1:0] angle_reg;
    logic [CW-1:0] dl_reg;
    logic [CW-1:0] dr_reg;

    logic [MA-1:0] travel_mag_reg;
    logic          travel_neg_reg;
    logic [QW-1:0] t_reg;
    logic [QW-1:0] x2_reg;
    logic [QW-1:0] u_reg;
    logic [QW-1:0] w_reg;
    logic [QW-1:0] s_reg;
    logic [QW-1:0] c_reg;
    logic [FB:0]   sin_mag_reg;
    logic [FB:0]   cos_mag_reg;
    logic          sin_neg_reg;
    logic          cos_neg_reg;

    logic                         m_tvalid_reg;
    logic [ddo_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [CW-1:0] left_raw;
    logic [CW-1:0] right_raw;
    logic [CW-1:0] left_use;
    logic [CW-1:0] right_use;
    logic [CW:0]   sum_w;
    logic [CW:0]   sum_mag;
    logic [CW:0]   diff_w;
    logic [CW:0]   diff_mag;

    ddo_pkg::step_t cur_step;
    logic [2:0]     oct;
    logic [QF-1:0]  r_red;
    logic           swap;
    logic [QW-1:0]  sin_src;
    logic [QW-1:0]  cos_src;
    logic [QW:0]    sin_rnd;
    logic [QW:0]    cos_rnd;

    logic                      mul_start;
    logic [MA-1:0]             mul_a;
    logic [MB-1:0]             mul_b;
    logic                      mul_done;
    logic [PRW-1:0]            mul_p;
    logic                      div_start;
    logic [QW-1:0]             div_dvd;
    logic [ddo_pkg::DIV_W-1:0] div_dsr;
    logic                      div_done;
    logic [QW-1:0]             div_q;
    logic                      unit_done;

    logic [PRW-1:0]    t_rnd;
    logic [PRW-1:0]    d_rnd;
    logic [PW+PRW-1:0] d_wide;
    logic [PW-1:0]     d_q;
    logic [PW-1:0]     dx_next;
    logic [PW-1:0]     dy_next;
    logic [AW-1:0]     turn_val;
    logic [QW-1:0]     p_q30;
    logic              out_load;
    logic [PW+OPW-1:0] x_ext;
    logic [PW+OPW-1:0] y_ext;

    assign left_raw  = s_tdata[CW-1:0];
    assign right_raw = s_tdata[ddo_pkg::IN_FIELD_W +: CW];
    assign left_use  = left_neg_reg  ? (~left_raw  + 1'b1) : left_raw;
    assign right_use = right_neg_reg ? (~right_raw + 1'b1) : right_raw;

    assign sum_w    = {dl_reg[CW-1], dl_reg} + {dr_reg[CW-1], dr_reg};
    assign sum_mag  = sum_w[CW] ? (~sum_w + 1'b1) : sum_w;
    assign diff_w   = {dr_reg[CW-1], dr_reg} - {dl_reg[CW-1], dl_reg};
    assign diff_mag = diff_w[CW] ? (~diff_w + 1'b1) : diff_w;

    assign cur_step = ddo_pkg::trig_step(step_reg);
    assign oct      = angle_reg[AW-1:AW-3];
    assign r_red    = oct[0] ? (QF'(1) << (QF - 1)) - {1'b0, angle_reg[AW-4:0]}
                             : {1'b0, angle_reg[AW-4:0]};
    assign swap     = oct[0] ^ oct[1];
    assign sin_src  = swap ? c_reg : s_reg;
    assign cos_src  = swap ? s_reg : c_reg;
    assign sin_rnd  = ({1'b0, sin_src} + (QW+1)'(RND_HALF)) >> SHIFT;
    assign cos_rnd  = ({1'b0, cos_src} + (QW+1)'(RND_HALF)) >> SHIFT;

    assign unit_done = mul_done | div_done;
    assign p_q30     = mul_p[QF +: QW];
    assign t_rnd     = mul_p + T_HALF;
    assign d_rnd     = mul_p + DX_HALF;
    assign d_wide    = {{PW{1'b0}}, d_rnd} >> FB;
    assign d_q       = d_wide[PW-1:0];
    assign dx_next   = (travel_neg_reg ^ cos_neg_reg) ? (~d_q + 1'b1) : d_q;
    assign dy_next   = (travel_neg_reg ^ sin_neg_reg) ? (~d_q + 1'b1) : d_q;
    assign turn_val  = diff_w[CW] ? (~mul_p[AW-1:0] + 1'b1) : mul_p[AW-1:0];
    assign out_load  = !m_tvalid_reg || m_tready;
    assign x_ext     = {{OPW{1'b0}}, pos_x_reg};
    assign y_ext     = {{OPW{1'b0}}, pos_y_reg};

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_dvd   = '0;
        div_dsr   = cur_step.divisor;
        unique case (state_reg)
            S_TRAVEL: begin
                mul_start = !pending_reg;
                mul_a     = MA'(sum_mag);
                mul_b     = MB'(half_dist_reg);
            end
            S_TMUL: begin
                mul_start = !pending_reg;
                mul_a     = MA'(ddo_pkg::QUARTER_PI_Q30);
                mul_b     = MB'(r_red);
            end
            S_TRIG: begin
                unique case (cur_step.kind)
                    ddo_pkg::STEP_SQ: begin
                        mul_start = !pending_reg;
                        mul_a     = MA'(t_reg);
                        mul_b     = t_reg;
                    end
                    ddo_pkg::STEP_MUL_W: begin
                        mul_start = !pending_reg;
                        mul_a     = MA'(x2_reg);
                        mul_b     = u_reg;
                    end
                    ddo_pkg::STEP_MUL_S: begin
                        mul_start = !pending_reg;
                        mul_a     = MA'(t_reg);
                        mul_b     = u_reg;
                    end
                    ddo_pkg::STEP_DIV_X2_U: begin
                        div_start = !pending_reg;
                        div_dvd   = x2_reg;
                    end
                    ddo_pkg::STEP_DIV_W_U, ddo_pkg::STEP_DIV_W_C: begin
                        div_start = !pending_reg;
                        div_dvd   = w_reg;
                    end
                    default: begin
                    end
                endcase
            end
            S_DX: begin
                mul_start = !pending_reg;
                mul_a     = travel_mag_reg;
                mul_b     = MB'(cos_mag_reg);
            end
            S_DY: begin
                mul_start = !pending_reg;
                mul_a     = travel_mag_reg;
                mul_b     = MB'(sin_mag_reg);
            end
            S_TURN: begin
                mul_start = !pending_reg;
                mul_a     = MA'(diff_mag);
                mul_b     = MB'(turn_reg);
            end
            default: begin
            end
        endcase
    end

    ddo_serial_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    ddo_const_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_dist_reg <= ddo_pkg::HALF_DIST_RESET;
            turn_reg      <= ddo_pkg::TURN_RESET;
            left_neg_reg  <= ddo_pkg::LEFT_NEG_RESET;
            right_neg_reg <= ddo_pkg::RIGHT_NEG_RESET;
        end else if (cfg_wr_en) begin
            unique case (ddo_pkg::cfg_reg_t'(cfg_addr))
                ddo_pkg::REG_HALF_DIST: half_dist_reg <= cfg_wdata;
                ddo_pkg::REG_TURN:      turn_reg      <= cfg_wdata;
                ddo_pkg::REG_LEFT_NEG:  left_neg_reg  <= cfg_wdata[0];
                ddo_pkg::REG_RIGHT_NEG: right_neg_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pending_reg    <= 1'b0;
            step_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
            last_left_reg  <= '0;
            last_right_reg <= '0;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            angle_reg      <= '0;
        end else begin
            if (mul_start || div_start) begin
                pending_reg <= 1'b1;
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        dl_reg         <= left_use - last_left_reg;
                        dr_reg         <= right_use - last_right_reg;
                        last_left_reg  <= left_use;
                        last_right_reg <= right_use;
                        state_reg      <= S_TRAVEL;
                    end
                end
                S_TRAVEL: begin
                    if (pending_reg && unit_done) begin
                        pending_reg    <= 1'b0;
                        travel_mag_reg <= mul_p[MA-1:0];
                        travel_neg_reg <= sum_w[CW];
                        state_reg      <= S_TMUL;
                    end
                end
                S_TMUL: begin
                    if (pending_reg && unit_done) begin
                        pending_reg <= 1'b0;
                        t_reg       <= t_rnd[QF-1 +: QW];
                        step_reg    <= '0;
                        state_reg   <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    if (cur_step.kind == ddo_pkg::STEP_END) begin
                        state_reg <= S_ROUND;
                    end else if (pending_reg && unit_done) begin
                        pending_reg <= 1'b0;
                        step_reg    <= step_reg + 1'b1;
                        unique case (cur_step.kind)
                            ddo_pkg::STEP_SQ:    x2_reg <= p_q30;
                            ddo_pkg::STEP_MUL_W: w_reg  <= p_q30;
                            ddo_pkg::STEP_MUL_S: s_reg  <= p_q30;
                            ddo_pkg::STEP_DIV_X2_U, ddo_pkg::STEP_DIV_W_U:
                                u_reg <= ddo_pkg::Q_ONE - div_q;
                            ddo_pkg::STEP_DIV_W_C:
                                c_reg <= ddo_pkg::Q_ONE - div_q;
                            default: begin
                            end
                        endcase
                    end
                end
                S_ROUND: begin
                    sin_mag_reg <= sin_rnd[FB:0];
                    cos_mag_reg <= cos_rnd[FB:0];
                    sin_neg_reg <= oct[2];
                    cos_neg_reg <= oct[2] ^ oct[1];
                    state_reg   <= S_DX;
                end
                S_DX: begin
                    if (pending_reg && unit_done) begin
                        pending_reg <= 1'b0;
                        pos_x_reg   <= pos_x_reg + dx_next;
                        state_reg   <= S_DY;
                    end
                end
                S_DY: begin
                    if (pending_reg && unit_done) begin
                        pending_reg <= 1'b0;
                        pos_y_reg   <= pos_y_reg + dy_next;
                        state_reg   <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (pending_reg && unit_done) begin
                        pending_reg <= 1'b0;
                        angle_reg   <= angle_reg + turn_val;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tdata_reg  <= {angle_reg, y_ext[OPW-1:0], x_ext[OPW-1:0]};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ hw/rtl/ddo_checker.sv @@
// Port-level checks for the odometry core, bound to its top level.
module ddo_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ddo_pkg::M_TDATA_W-1:0] m_tdata
);
    // A stalled result stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // After an item is taken the core is busy and takes no second one at once.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted back to back");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");
endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
